// ===== rtl/tlrc_pkg.sv =====
// Shared types, constants and the CRC step for the telegram receive checker.
package tlrc_pkg;

   localparam logic [15:0] CRC_POLY       = 16'h8005;
   localparam logic [7:0]  START_BYTE     = 8'h02;
   localparam logic [7:0]  ADDR_BYTE      = 8'h80;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd6;
   localparam logic [16:0] MIN_MAX_LEN    = 17'd7;
   localparam logic [16:0] MAX_LEN_RESET  = 17'd1024;

   // Status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_START = 3'd1;
   localparam logic [2:0] STATUS_BAD_ADDR  = 3'd2;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
   localparam logic [2:0] STATUS_CRC_ERR   = 3'd4;

   // Header byte positions
   localparam logic [1:0] HDR_START  = 2'd0;
   localparam logic [1:0] HDR_ADDR   = 2'd1;
   localparam logic [1:0] HDR_LEN_LO = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_BODY   = 2'b10
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        frame_done;
      logic [2:0]  status;
      logic [16:0] frame_length;
   } result_type;

   // One byte step: shift with feedback, then mix in previous and current byte.
   function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                            input logic [7:0] prev_byte,
                                            input logic [7:0] cur_byte);
      logic [15:0] shifted;
      shifted = {crc[14:0], 1'b0};
      if (crc[15]) begin
         shifted = shifted ^ CRC_POLY;
      end
      return shifted ^ {prev_byte, cur_byte};
   endfunction

endpackage

// ===== rtl/tlrc_core.sv =====
// Frame state and per-item decode: header checks, data forwarding, CRC.
module tlrc_core
   import tlrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   input  logic [16:0] max_frame_len,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [16:0] byte_count_ff, byte_count_in;
   logic [16:0] total_length_ff, total_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [1:0]  hdr_flags_ff, hdr_flags_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic [16:0] hdr_len;
   logic [17:0] count_plus2;
   logic [15:0] crc_fed;
   logic        restart;

   assign hdr_len     = FRAME_OVERHEAD + {9'd0, len_lo_ff} + {1'b0, rx_byte, 8'd0};
   assign count_plus2 = {1'b0, byte_count_ff} + 18'd2;
   assign crc_fed     = crc_step(crc_ff, prev_byte_ff, rx_byte);

   // Next state and result for the incoming item
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      total_length_in = total_length_ff;
      crc_in          = crc_ff;
      prev_byte_in    = prev_byte_ff;
      hdr_flags_in    = hdr_flags_ff;
      len_lo_in       = len_lo_ff;
      crc_lo_in       = crc_lo_ff;
      restart         = 1'b0;
      result          = '0;

      case (phase_ff)
         PH_HEADER: begin
            crc_in       = crc_fed;
            prev_byte_in = rx_byte;
            case (byte_count_ff[1:0])
               HDR_START: begin
                  if (rx_byte != START_BYTE) hdr_flags_in[0] = 1'b1;
                  byte_count_in = 17'd1;
               end
               HDR_ADDR: begin
                  if (rx_byte != ADDR_BYTE) hdr_flags_in[1] = 1'b1;
                  byte_count_in = 17'd2;
               end
               HDR_LEN_LO: begin
                  len_lo_in     = rx_byte;
                  byte_count_in = 17'd3;
               end
               default: begin
                  result.frame_length = hdr_len;
                  if (hdr_flags_ff[0]) begin
                     result.frame_done = 1'b1;
                     result.status     = STATUS_BAD_START;
                  end else if (hdr_flags_ff[1]) begin
                     result.frame_done = 1'b1;
                     result.status     = STATUS_BAD_ADDR;
                  end else if (max_frame_len < MIN_MAX_LEN || hdr_len > max_frame_len) begin
                     result.frame_done = 1'b1;
                     result.status     = STATUS_TOO_LONG;
                  end
                  if (result.frame_done) begin
                     restart = 1'b1;
                  end else begin
                     phase_in        = PH_BODY;
                     total_length_in = hdr_len;
                     byte_count_in   = 17'd4;
                  end
               end
            endcase
         end
         PH_BODY: begin
            result.frame_length = total_length_ff;
            if (count_plus2 < {1'b0, total_length_ff}) begin
               // answer or data byte
               result.data_byte  = rx_byte;
               result.data_valid = 1'b1;
               crc_in            = crc_fed;
               prev_byte_in      = rx_byte;
               byte_count_in     = byte_count_ff + 17'd1;
            end else if (count_plus2 == {1'b0, total_length_ff}) begin
               crc_lo_in     = rx_byte;
               byte_count_in = byte_count_ff + 17'd1;
            end else begin
               // last byte: compare received CRC pair
               result.frame_done = 1'b1;
               result.status     = ({rx_byte, crc_lo_ff} == crc_ff) ? STATUS_OK
                                                                    : STATUS_CRC_ERR;
               restart           = 1'b1;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      if (restart) begin
         phase_in        = PH_HEADER;
         byte_count_in   = '0;
         total_length_in = '0;
         crc_in          = '0;
         prev_byte_in    = '0;
         hdr_flags_in    = '0;
         len_lo_in       = '0;
         crc_lo_in       = '0;
      end
   end

   // State registers, updated only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         byte_count_ff   <= '0;
         total_length_ff <= '0;
         crc_ff          <= '0;
         prev_byte_ff    <= '0;
         hdr_flags_ff    <= '0;
         len_lo_ff       <= '0;
         crc_lo_ff       <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         total_length_ff <= total_length_in;
         crc_ff          <= crc_in;
         prev_byte_ff    <= prev_byte_in;
         hdr_flags_ff    <= hdr_flags_in;
         len_lo_ff       <= len_lo_in;
         crc_lo_ff       <= crc_lo_in;
      end
   end

endmodule

// ===== rtl/tlrc_out.sv =====
// Result register with valid flag; frees itself in the cycle the item is taken.
module tlrc_out
   import tlrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_result,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // Load when empty or when the held item leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/telegram_receive_checker.sv =====
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while results are taken; a result held in the
// single result register stalls the input until it leaves (one CRC byte step per cycle).
// Reset (synchronous, active high) returns to the header phase, clears the CRC
// and counters, empties the result register and sets max_frame_len to 1024.
module telegram_receive_checker
   import tlrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [16:0] csr_wdata,    // max_frame_len
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] data_byte, [10:8] status,
                                     // [27:11] frame_length, [31:28] zero
   output logic        rsp_tlast,    // frame_done
   output logic        rsp_tuser     // data_valid
);

   logic [16:0] max_len_ff;
   logic        accept;
   result_type  core_result;
   result_type  rsp_result;

   // Maximum frame length register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   assign accept = req_tvalid && req_tready;

   tlrc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_tdata),
      .max_frame_len (max_len_ff),
      .result        (core_result)
   );

   tlrc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_result  (core_result),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // Pack result item onto the stream
   assign rsp_tdata = {4'd0, rsp_result.frame_length, rsp_result.status,
                       rsp_result.data_byte};
   assign rsp_tlast = rsp_result.frame_done;
   assign rsp_tuser = rsp_result.data_valid;

endmodule

// ===== sim/telegram_receive_checker_tb.sv =====
// Self-checking testbench for the telegram receive checker: header, length and CRC checks.
module telegram_receive_checker_tb;
   import tlrc_pkg::*;

   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS      = 55;
   localparam int NUM_PHASES       = 10;

   // Telegram predictor plus the queue of results still owed by the block
   class telegram_scoreboard;
      result_type  expected_q[$];
      int          errors;
      logic [16:0] max_len;
      phase_type   phase;
      logic [16:0] byte_count;
      logic [16:0] total_len;
      logic [15:0] crc;
      logic [7:0]  prev_byte;
      logic [1:0]  hdr_flags;    // bit 0 bad start, bit 1 bad address
      logic [7:0]  len_lo;
      logic [7:0]  crc_lo;

      function new();
         errors  = 0;
         max_len = MAX_LEN_RESET;
         clear_frame();
      endfunction

      // One CRC byte step: shift with feedback, mix in previous and current byte
      static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] p, logic [7:0] b);
         logic [15:0] s;
         s = {c[14:0], 1'b0} ^ (c[15] ? CRC_POLY : 16'h0000);
         return s ^ {p, b};
      endfunction

      function void clear_frame();
         phase      = PH_HEADER;
         byte_count = '0;
         total_len  = '0;
         crc        = '0;
         prev_byte  = '0;
         hdr_flags  = '0;
         len_lo     = '0;
         crc_lo     = '0;
      endfunction

      function void feed(logic [7:0] b);
         crc       = crc_next(crc, prev_byte, b);
         prev_byte = b;
      endfunction

      function void set_max(logic [16:0] v);
         max_len = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Expected result for one received byte
      function result_type predict(logic [7:0] b);
         result_type  r;
         logic [16:0] len;
         r = '0;
         if (phase == PH_HEADER) begin
            feed(b);
            if (byte_count == HDR_START) begin
               hdr_flags[0] = (b != START_BYTE);
               byte_count   = byte_count + 17'd1;
            end else if (byte_count == HDR_ADDR) begin
               hdr_flags[1] = (b != ADDR_BYTE);
               byte_count   = byte_count + 17'd1;
            end else if (byte_count == HDR_LEN_LO) begin
               len_lo     = b;
               byte_count = byte_count + 17'd1;
            end else begin
               // all four header bytes in: start, then address, then length
               len = FRAME_OVERHEAD + {9'd0, len_lo} + {1'b0, b, 8'd0};
               r.frame_length = len;
               if (hdr_flags[0]) begin
                  r.status = STATUS_BAD_START;
               end else if (hdr_flags[1]) begin
                  r.status = STATUS_BAD_ADDR;
               end else if (max_len < MIN_MAX_LEN || len > max_len) begin
                  r.status = STATUS_TOO_LONG;
               end
               if (r.status != STATUS_OK) begin
                  r.frame_done = 1'b1;
                  clear_frame();
               end else begin
                  phase      = PH_BODY;
                  total_len  = len;
                  byte_count = byte_count + 17'd1;
               end
            end
         end else begin
            r.frame_length = total_len;
            if (byte_count + 17'd2 < total_len) begin
               r.data_byte  = b;
               r.data_valid = 1'b1;
               feed(b);
               byte_count = byte_count + 17'd1;
            end else if (byte_count + 17'd2 == total_len) begin
               crc_lo     = b;
               byte_count = byte_count + 17'd1;
            end else begin
               // last byte: compare the low-first CRC pair
               r.frame_done = 1'b1;
               r.status     = ({b, crc_lo} == crc) ? STATUS_OK : STATUS_CRC_ERR;
               clear_frame();
            end
         end
         return r;
      endfunction

      function void note_byte(logic [7:0] b);
         expected_q.push_back(predict(b));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no byte pending, expected none actual %h", $time, got);
         end else begin
            want = expected_q.pop_front();
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("data_valid", want.data_valid, got.data_valid);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("status", want.status, got.status);
            compare_field("frame_length", want.frame_length, got.frame_length);
         end
      endfunction

      function void close_out();
         if (expected_q.size() != 0) begin
            errors += expected_q.size();
            $display("%0t: %0d results never arrived, next expected %h actual none",
                     $time, expected_q.size(), expected_q[0]);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [16:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   bit          idle_enable = 1'b1;
   bit          hold_rsp    = 1'b0;
   int          sent_items  = 0;
   logic [16:0] max_plan[NUM_PHASES];
   telegram_scoreboard frame_sb;

   telegram_receive_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor both channels at the clock edge
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.data_byte    = rsp_tdata[7:0];
            got.status       = rsp_tdata[10:8];
            got.frame_length = rsp_tdata[27:11];
            got.frame_done   = rsp_tlast;
            got.data_valid   = rsp_tuser;
            frame_sb.check_result(got);
         end
         if (req_tvalid && req_tready) begin
            frame_sb.note_byte(req_tdata);
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin : rsp_driver
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Offer one byte, with an occasional gap before it
   task automatic send_byte(input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // Build a telegram; a rejected header is sent alone since the block drops it there
   task automatic send_frame(input logic [7:0] start_b, input logic [7:0] addr_b,
                             input logic [15:0] count, input bit bad_crc);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      logic [7:0]  prev;
      int          len;
      frame_q.push_back(start_b);
      frame_q.push_back(addr_b);
      frame_q.push_back(count[7:0]);
      frame_q.push_back(count[15:8]);
      len = 6 + count;
      if (start_b == START_BYTE && addr_b == ADDR_BYTE && frame_sb.max_len >= MIN_MAX_LEN
          && len <= frame_sb.max_len) begin
         for (int i = 0; i < count; i++) begin
            frame_q.push_back(8'($urandom_range(0, 255)));
         end
         crc  = '0;
         prev = '0;
         foreach (frame_q[i]) begin
            crc  = telegram_scoreboard::crc_next(crc, prev, frame_q[i]);
            prev = frame_q[i];
         end
         if (bad_crc) begin
            crc ^= 16'(1) << $urandom_range(0, 15);
         end
         frame_q.push_back(crc[7:0]);
         frame_q.push_back(crc[15:8]);
      end
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   // Mostly good telegrams, plus broken headers, overlong and boundary lengths
   task automatic send_random_frame();
      int          pick;
      int          room;
      logic [7:0]  s;
      logic [7:0]  a;
      logic [15:0] count;
      pick  = $urandom_range(0, 99);
      room  = int'(frame_sb.max_len) - 6;    // largest count that still fits
      s     = START_BYTE;
      a     = ADDR_BYTE;
      count = 16'($urandom_range(0, 8));
      if ($urandom_range(0, 4) == 0) begin
         count = 16'($urandom_range(0, 40));
      end
      if (pick < 10) begin
         s = 8'($urandom_range(0, 255));
         a = 8'($urandom_range(0, 255));
         if (s == START_BYTE && a == ADDR_BYTE) begin
            a = ~a;
         end
      end else if (pick < 18 && room < 65535) begin
         count = 16'($urandom_range((room < 0) ? 0 : room + 1, 65535));
         if ($urandom_range(0, 1) == 0 && room >= 0) begin
            count = 16'(room + 1);
         end
      end else if (pick < 25 && room >= 0 && room <= 40) begin
         count = 16'(room);
      end
      send_frame(s, a, count, $urandom_range(0, 4) == 0);
   endtask

   // Stop offering and wait until every owed result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (frame_sb.pending() != 0);
   endtask

   task automatic set_max_len(input logic [16:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      frame_sb.set_max(v);
   endtask

   initial begin : stimulus
      int phase_start;
      frame_sb = new();
      max_plan = '{17'd7, 17'd0, 17'h1FFFF, 17'd65541, 17'd65540, 17'd6, 17'd20,
                   17'd7, 17'd7, 17'd1024};
      max_plan[7] = 17'($urandom_range(7, 64));
      max_plan[8] = 17'($urandom_range(7, 300));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed telegrams under the reset maximum
      send_frame(START_BYTE, ADDR_BYTE, 16'd0, 1'b0);     // empty data
      send_frame(8'hFF, 8'h00, 16'hFFFF, 1'b0);           // bad start wins over the rest
      send_frame(START_BYTE, 8'h7F, 16'd3, 1'b0);         // bad address
      send_frame(START_BYTE, ADDR_BYTE, 16'hFFFF, 1'b0);  // too long, longest length
      send_frame(START_BYTE, ADDR_BYTE, 16'd1, 1'b1);     // CRC mismatch
      drain();

      // random phases, one per maximum length setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_max_len(max_plan[p]);
         if (p == 0) begin
            hold_rsp = 1'b1;
         end
         if (p == NUM_PHASES - 1) begin
            idle_enable = 1'b0;
         end
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) send_random_frame();
         drain();
      end

      repeat (4) @(posedge clock);
      frame_sb.close_out();
      if (frame_sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #16000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tlrc_pkg.sv
rtl/tlrc_core.sv
rtl/tlrc_out.sv
rtl/telegram_receive_checker.sv
sim/telegram_receive_checker_tb.sv
